@@ design/isc_pkg.sv @@
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants of the itemset support counter.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int ChunkW     = 64;
  localparam int CountW     = 32;
  localparam int RowsUsedW  = 11;
  localparam int RowLimitW  = 11;
  localparam int NumColsW   = 9;
  localparam int StatusW    = 2;
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  // Item commands.
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StQuery  = 2'd0;
  localparam logic [StatusW-1:0] StMerged = 2'd1;
  localparam logic [StatusW-1:0] StAdded  = 2'd2;
  localparam logic [StatusW-1:0] StFull   = 2'd3;

  // Register select (paddr bit 2).
  localparam logic RegRowLimit = 1'b0;
  localparam logic RegNumCols  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_chunk;
    logic start;
    logic rd_en;
    logic commit;
  } isc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chunk_final;
  } isc_sts_t;

endpackage

@@ design/itemset_support_counter.sv @@
// ----------------------------------------------------------------------------
// itemset_support_counter
// Table of distinct transaction bitmaps with occurrence counts; answers
// support queries as saturated sums of counts of containing rows.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Beat contents
//  ------    ---------  -------------------  -----------------------------------
//  in        sink       in_valid/in_ready    cmd, chunk_data, chunk_last
//  out       source     out_valid/out_ready  status, match_count, rows_used
//  cfg       APB slave  psel/penable/pready  row_limit (0x0), num_columns (0x4)
//
// Each beat is taken into the assembly buffer. The completing beat starts
// a scan of the row memory, one stored row per cycle; then the result
// passes through StDrain to StCommit, which waits for the output register
// to be free. Input is not taken during the scan. Reset clears the fill
// count and assembly buffer; the row memories need no clearing.
// ----------------------------------------------------------------------------
module itemset_support_counter #(
  parameter int ROWS    = 1024,
  parameter int COLUMNS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [isc_pkg::ChunkW-1:0]      chunk_data_i,
  input  logic                            chunk_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [isc_pkg::StatusW-1:0]     status_o,
  output logic [isc_pkg::CountW-1:0]      match_count_o,
  output logic [isc_pkg::RowsUsedW-1:0]   rows_used_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [isc_pkg::PaddrW-1:0]      paddr,
  input  logic [isc_pkg::PdataW-1:0]      pwdata,
  output logic [isc_pkg::PdataW-1:0]      prdata,
  output logic                            pready
);

  localparam int RCW = $clog2(ROWS + 1);
  localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RuW = isc_pkg::RowsUsedW;
  localparam int DW  = isc_pkg::PdataW;

  logic [isc_pkg::RowLimitW-1:0] row_limit_q;
  logic [isc_pkg::NumColsW-1:0]  num_columns_q;
  logic                          cfg_wr;
  isc_pkg::isc_cmd_t             cmd;
  isc_pkg::isc_sts_t             sts;
  logic [AW-1:0]                 rd_addr;
  logic [RCW-1:0]                rows_used;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit_q   <= isc_pkg::RowLimitW'(1024);
      num_columns_q <= isc_pkg::NumColsW'(256);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        isc_pkg::RegRowLimit: row_limit_q   <= pwdata[isc_pkg::RowLimitW-1:0];
        isc_pkg::RegNumCols:  num_columns_q <= pwdata[isc_pkg::NumColsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      isc_pkg::RegRowLimit: prdata = DW'(row_limit_q);
      isc_pkg::RegNumCols:  prdata = DW'(num_columns_q);
      default:              prdata = '0;
    endcase
  end

  isc_ctrl #(.ROWS(ROWS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .rows_used_i (rows_used),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  isc_dp #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .sts_o         (sts),
    .item_cmd_i    (cmd_i),
    .chunk_data_i  (chunk_data_i),
    .chunk_last_i  (chunk_last_i),
    .row_limit_i   (row_limit_q),
    .num_columns_i (num_columns_q),
    .rows_used_o   (rows_used),
    .status_o      (status_o),
    .match_count_o (match_count_o)
  );

  assign rows_used_o = RuW'(rows_used);

  // A result is only committed when the output register is free.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("result committed over a pending beat");

  // The number of stored rows never shrinks and never exceeds the table.
  a_rows_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (rows_used >= $past(rows_used)) && (rows_used <= RCW'(ROWS)))
    else $error("row count went backward or past the table size");

  // Inserts report a zero support sum.
  a_insert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != isc_pkg::StQuery) |-> (match_count_o == '0))
    else $error("insert result carries a nonzero sum");

endmodule

@@ design/isc_ctrl.sv @@
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer: takes beats, runs one scan over the stored rows per bitmap,
// then commits the result into the output register.
// ----------------------------------------------------------------------------
module isc_ctrl #(
  parameter int ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  isc_pkg::isc_sts_t             sts_i,
  input  logic [$clog2(ROWS+1)-1:0]     rows_used_i,
  output isc_pkg::isc_cmd_t             cmd_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr_o
);

  localparam int RCW = $clog2(ROWS + 1);
  localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [RCW-1:0] row_q, row_d;
  logic           out_valid_q, out_valid_d;
  logic           accept;
  logic           out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign rd_addr_o   = row_q[AW-1:0];

  always_comb begin
    state_d          = state_q;
    row_d            = row_q;
    cmd_o.load_chunk = accept;
    cmd_o.start      = 1'b0;
    cmd_o.rd_en      = 1'b0;
    cmd_o.commit     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept && sts_i.chunk_final) begin
          cmd_o.start = 1'b1;
          row_d       = '0;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (row_q == rows_used_i) begin
          state_d = StDrain;
        end else begin
          cmd_o.rd_en = 1'b1;
          row_d       = row_q + 1'b1;
        end
      end
      StDrain: begin
        // The last row read has already been evaluated in StScan; this state only waits.
        state_d = StCommit;
      end
      StCommit: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = (out_valid_q & ~out_ready_i) | cmd_o.commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/isc_dp.sv @@
// ----------------------------------------------------------------------------
// isc_dp
// Datapath: bitmap assembly, row and count memories, compare and
// accumulate, and the result register.
// ----------------------------------------------------------------------------
module isc_dp #(
  parameter int ROWS    = 1024,
  parameter int COLUMNS = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  isc_pkg::isc_cmd_t                      cmd_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr_i,
  output isc_pkg::isc_sts_t                      sts_o,
  input  logic                                   item_cmd_i,
  input  logic [isc_pkg::ChunkW-1:0]             chunk_data_i,
  input  logic                                   chunk_last_i,
  input  logic [isc_pkg::RowLimitW-1:0]          row_limit_i,
  input  logic [isc_pkg::NumColsW-1:0]           num_columns_i,
  output logic [$clog2(ROWS+1)-1:0]              rows_used_o,
  output logic [isc_pkg::StatusW-1:0]            status_o,
  output logic [isc_pkg::CountW-1:0]             match_count_o
);

  localparam int CHUNKS = (COLUMNS + 63) / 64;
  localparam int KW     = CHUNKS * isc_pkg::ChunkW;
  localparam int CIW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int RCW    = $clog2(ROWS + 1);
  localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = isc_pkg::CountW;
  localparam int LW     = (RCW > isc_pkg::RowLimitW) ? RCW : isc_pkg::RowLimitW;
  localparam logic [LW-1:0] RowsMax = LW'(ROWS);

  logic [CIW-1:0]              idx_q;
  logic [isc_pkg::ChunkW-1:0]  buf_q [CHUNKS];
  logic                        pend_q;
  logic [KW-1:0]               assembled;
  logic [KW-1:0]               col_mask;
  logic [KW-1:0]               key_q;

  logic [KW-1:0]               row_mem [ROWS];
  logic [CW-1:0]               cnt_mem [ROWS];
  logic [KW-1:0]               row_q;
  logic [CW-1:0]               cnt_q;
  logic                        rd_vld_q;
  logic [AW-1:0]               rd_idx_q;

  logic [CW-1:0]               sum_q;
  logic                        found_q;
  logic [AW-1:0]               match_idx_q;
  logic [CW-1:0]               match_cnt_q;
  logic [RCW-1:0]              rows_used_q;
  logic [isc_pkg::StatusW-1:0] status_q;
  logic [CW-1:0]               match_count_q;

  logic                        is_query;
  logic                        row_hit;
  logic                        row_eq;
  logic [CW:0]                 sum_ext;
  logic [CW-1:0]               sum_sat;
  logic [CW-1:0]               inc_cnt;
  logic                        room;
  logic [isc_pkg::StatusW-1:0] status_d;

  assign sts_o.chunk_final = chunk_last_i || (idx_q == CIW'(CHUNKS - 1));

  // The incoming beat replaces its slot; slots never written read as zero.
  for (genvar c = 0; c < CHUNKS; c++) begin : g_asm
    assign assembled[c*isc_pkg::ChunkW +: isc_pkg::ChunkW] =
        (idx_q == CIW'(c)) ? chunk_data_i : buf_q[c];
  end

  for (genvar i = 0; i < KW; i++) begin : g_mask
    assign col_mask[i] = (i < COLUMNS) && (i < int'(num_columns_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= isc_pkg::CmdInsert;
      for (int c = 0; c < CHUNKS; c++) begin
        buf_q[c] <= '0;
      end
    end else if (cmd_i.load_chunk) begin
      if (idx_q == '0) begin
        pend_q <= item_cmd_i;
      end
      if (cmd_i.start) begin
        idx_q <= '0;
        for (int c = 0; c < CHUNKS; c++) begin
          buf_q[c] <= '0;
        end
      end else begin
        idx_q <= idx_q + 1'b1;
        for (int c = 0; c < CHUNKS; c++) begin
          if (idx_q == CIW'(c)) begin
            buf_q[c] <= chunk_data_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= assembled & col_mask;
    end
  end

  assign is_query = (pend_q == isc_pkg::CmdQuery);
  assign row_hit  = ((row_q & key_q) == key_q);
  assign row_eq   = (row_q == key_q);
  assign sum_ext  = {1'b0, sum_q} + {1'b0, cnt_q};
  assign sum_sat  = sum_ext[CW] ? '1 : sum_ext[CW-1:0];
  assign inc_cnt  = (match_cnt_q == '1) ? match_cnt_q : match_cnt_q + 1'b1;
  assign room     = (LW'(rows_used_q) < LW'(row_limit_i)) &&
                    (LW'(rows_used_q) < RowsMax);

  always_comb begin
    if (is_query) begin
      status_d = isc_pkg::StQuery;
    end else if (found_q) begin
      status_d = isc_pkg::StMerged;
    end else if (room) begin
      status_d = isc_pkg::StAdded;
    end else begin
      status_d = isc_pkg::StFull;
    end
  end

  // Memories: one read port for the scan, one write port for the commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      row_q <= row_mem[rd_addr_i];
      cnt_q <= cnt_mem[rd_addr_i];
    end
    if (cmd_i.commit && status_d == isc_pkg::StMerged) begin
      cnt_mem[match_idx_q] <= inc_cnt;
    end
    if (cmd_i.commit && status_d == isc_pkg::StAdded) begin
      row_mem[rows_used_q[AW-1:0]] <= key_q;
      cnt_mem[rows_used_q[AW-1:0]] <= CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_idx_q <= rd_addr_i;
    end
    if (rd_vld_q && !is_query && row_eq) begin
      match_idx_q <= rd_idx_q;
      match_cnt_q <= cnt_q;
    end
    if (cmd_i.commit) begin
      status_q      <= status_d;
      match_count_q <= is_query ? sum_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      sum_q       <= '0;
      found_q     <= 1'b0;
      rows_used_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        sum_q   <= '0;
        found_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (is_query && row_hit) begin
          sum_q <= sum_sat;
        end
        if (!is_query && row_eq) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit && status_d == isc_pkg::StAdded) begin
        rows_used_q <= rows_used_q + 1'b1;
      end
    end
  end

  assign rows_used_o   = rows_used_q;
  assign status_o      = status_q;
  assign match_count_o = match_count_q;

endmodule
